// ===== src/bsu_pkg.sv =====
// Package for the bounded stack unit: sizes, operation and status codes,
// and the control word shared by the cell chain. No dependencies.
`default_nettype none
package bsu_pkg;
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W = 5;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int WORD_W = 32;
    localparam int STAT_W = 3;

    localparam logic [1:0] KIND_PUSH    = 2'd0;
    localparam logic [1:0] KIND_POP     = 2'd1;
    localparam logic [1:0] KIND_CHANGE  = 2'd2;
    localparam logic [1:0] KIND_DISPLAY = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW    = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_PRESENT = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY       = 3'd4;

    localparam logic [2:0] OP_HOLD  = 3'd0;
    localparam logic [2:0] OP_PUSH  = 3'd1;
    localparam logic [2:0] OP_POP   = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_ROT   = 3'd4;

    typedef struct packed {
        logic [2:0]               op;
        logic signed [WORD_W-1:0] wdata;
        logic [IDX_W-1:0]         wr_idx;
        logic [IDX_W-1:0]         last_idx;
    } t_cell_ctl;
endpackage
`default_nettype wire

// ===== src/bsu_cell.sv =====
// One stack cell: holds one entry and trades it with its neighbors.
// Depends on bsu_pkg.
`default_nettype none
module bsu_cell
    import bsu_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_cell_ctl                i_ctl,
    input  wire logic [IDX_W-1:0]         i_idx,
    input  wire logic signed [WORD_W-1:0] i_prev,
    input  wire logic signed [WORD_W-1:0] i_next,
    input  wire logic signed [WORD_W-1:0] i_top,
    output logic signed [WORD_W-1:0]      o_data
);
    logic signed [WORD_W-1:0] r_data;
    logic signed [WORD_W-1:0] n_data;

    always_comb begin
        case (i_ctl.op)
            OP_PUSH:  n_data = i_prev;
            OP_POP:   n_data = i_next;
            OP_WRITE: n_data = (i_idx == i_ctl.wr_idx) ? i_ctl.wdata : r_data;
            OP_ROT:   n_data = (i_idx == i_ctl.last_idx) ? i_top : i_next;
            default:  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
endmodule
`default_nettype wire

// ===== src/bounded_stack_with_indexed_update_unit.sv =====
// Bounded stack unit: a chain of cells with the top entry in cell 0.
// Push, pop and change: one transfer in per cycle unless the output stalls;
// result registered for the cycle after. Display: accepted, then one entry per
// cycle unless the output stalls, as the filled part of the chain rotates through cell 0.
// Reset (synchronous, active low) empties the stack and drops any pending
// result; entries are not cleared. Depends on bsu_pkg and bsu_cell.
`default_nettype none
module bounded_stack_with_indexed_update_unit
    import bsu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // value[31:0], position[36:32], zero pad
    input  wire logic [1:0]  i_s_tuser,   // kind[1:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // status[2:0], data[34:3], zero pad
    output logic             o_m_tlast
);
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [CNT_W-1:0]         r_left, n_left;
    logic                     r_disp, n_disp;
    logic                     r_ovalid;
    logic [STAT_W-1:0]        r_ostatus, n_ostatus;
    logic signed [WORD_W-1:0] r_odata, n_odata;
    logic                     r_olast, n_olast;
    logic                     w_load;
    logic                     w_slot;
    logic                     w_acc;
    t_cell_ctl                w_ctl;
    logic [1:0]               w_kind;
    logic signed [WORD_W-1:0] w_value;
    logic [POS_W-1:0]         w_pos;
    logic [CMP_W-1:0]         w_pos_m1;
    logic [CNT_W-1:0]         w_cnt_m1;
    logic signed [WORD_W-1:0] w_cell [DEPTH];

    assign w_kind   = i_s_tuser;
    assign w_value  = i_s_tdata[31:0];
    assign w_pos    = i_s_tdata[36:32];
    assign w_pos_m1 = CMP_W'(w_pos) - CMP_W'(1);
    assign w_cnt_m1 = r_cnt - CNT_W'(1);

    assign w_slot     = !r_ovalid || i_m_tready;
    assign o_s_tready = !r_disp && w_slot;
    assign w_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        w_ctl.op       = OP_HOLD;
        w_ctl.wdata    = w_value;
        w_ctl.wr_idx   = w_pos_m1[IDX_W-1:0];
        w_ctl.last_idx = w_cnt_m1[IDX_W-1:0];
        n_cnt     = r_cnt;
        n_disp    = r_disp;
        n_left    = r_left;
        w_load    = 1'b0;
        n_ostatus = ST_OK;
        n_odata   = '0;
        n_olast   = 1'b1;
        if (r_disp && w_slot) begin
            w_ctl.op = OP_ROT;
            w_load   = 1'b1;
            n_odata  = w_cell[0];
            n_olast  = (r_left == CNT_W'(1));
            n_left   = r_left - CNT_W'(1);
            n_disp   = (r_left != CNT_W'(1));
        end else if (w_acc) begin
            w_load = 1'b1;
            case (w_kind)
                KIND_PUSH: begin
                    if (r_cnt == CNT_W'(DEPTH)) begin
                        n_ostatus = ST_OVERFLOW;
                    end else begin
                        w_ctl.op = OP_PUSH;
                        n_cnt    = r_cnt + CNT_W'(1);
                    end
                end
                KIND_POP: begin
                    if (r_cnt == '0) begin
                        n_ostatus = ST_UNDERFLOW;
                        n_odata   = '1;
                    end else begin
                        w_ctl.op = OP_POP;
                        n_odata  = w_cell[0];
                        n_cnt    = w_cnt_m1;
                    end
                end
                KIND_CHANGE: begin
                    if (w_pos == '0 || CMP_W'(w_pos) > CMP_W'(r_cnt)) begin
                        n_ostatus = ST_NOT_PRESENT;
                    end else begin
                        w_ctl.op = OP_WRITE;
                    end
                end
                default: begin
                    if (r_cnt == '0) begin
                        n_ostatus = ST_EMPTY;
                    end else begin
                        w_load = 1'b0;
                        n_disp = 1'b1;
                        n_left = r_cnt;
                    end
                end
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [WORD_W-1:0] w_prev;
            logic signed [WORD_W-1:0] w_next;
            if (g == 0) begin : g_first
                assign w_prev = w_value;
            end else begin : g_mid
                assign w_prev = w_cell[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_next = '0;
            end else begin : g_inner
                assign w_next = w_cell[g+1];
            end
            bsu_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl),
                .i_idx  (IDX_W'(g)),
                .i_prev (w_prev),
                .i_next (w_next),
                .i_top  (w_cell[0]),
                .o_data (w_cell[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_left   <= '0;
            r_disp   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_left <= n_left;
            r_disp <= n_disp;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ostatus <= n_ostatus;
            r_odata   <= n_odata;
            r_olast   <= n_olast;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'd0, r_odata, r_ostatus};
    assign o_m_tlast  = r_olast;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_disp_cnt_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disp && $past(r_disp) |-> r_cnt == $past(r_cnt))
        else $error("fill count moved during display");

    a_disp_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disp |-> (r_left != '0) && (r_left <= r_cnt))
        else $error("display count out of range");

    a_underflow_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && (r_ostatus == ST_UNDERFLOW) |-> (r_odata == '1) && r_olast)
        else $error("underflow result malformed");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for bounded_stack_with_indexed_update_unit: directed table, then biased random
// push/pop/change/display traffic with random stalls, checked against a stack predictor.
// Depends on bsu_pkg and the unit's RTL.
module tb_top;
    import bsu_pkg::*;

    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 211;
    localparam int QUIET_FROM    = 170;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [WORD_W-1:0] data;
        logic                     last;
    } t_result;

    typedef struct {
        logic [1:0]               kind;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]         pos;
        int                       reps;
        bit                       typed;
        logic [STAT_W-1:0]        status;
        logic signed [WORD_W-1:0] data;
    } t_stim_row;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [1:0]               s_kind = KIND_PUSH;
    logic signed [WORD_W-1:0] s_value = '0;
    logic [POS_W-1:0]         s_pos = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [39:0]              m_tdata;
    logic                     m_tlast;

    // typed expectation that travels with the current item
    bit                       row_typed = 1'b0;
    logic [STAT_W-1:0]        typed_status = ST_OK;
    logic signed [WORD_W-1:0] typed_data = '0;

    bit                       quiet = 1'b0;
    int                       stall_left = 0;

    logic signed [WORD_W-1:0] stack_words [DEPTH];
    int                       stack_fill = 0;
    t_result                  step_results [$];
    t_result                  awaited_results [$];
    t_stim_row                directed_rows [$];

    int errors = 0;
    int items_in = 0;
    int results_out = 0;
    int stall_cycles = 0;
    int status_seen [5];

    bounded_stack_with_indexed_update_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  ({3'b000, s_pos, s_value}),   // value[31:0], position[36:32], zero pad
        .i_s_tuser  (s_kind),                     // kind[1:0]
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),                    // status[2:0], data[34:3], zero pad
        .o_m_tlast  (m_tlast)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void predict_stack_op(input logic [1:0] kind,
                                             input logic signed [WORD_W-1:0] word,
                                             input logic [POS_W-1:0] pos);
        t_result r;
        step_results.delete();
        r.status = ST_OK;
        r.data   = '0;
        r.last   = 1'b1;
        case (kind)
            KIND_PUSH: begin
                if (stack_fill >= DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    stack_words[stack_fill] = word;
                    stack_fill++;
                end
            end
            KIND_POP: begin
                if (stack_fill == 0) begin
                    r.status = ST_UNDERFLOW;
                    r.data   = -1;
                end else begin
                    stack_fill--;
                    r.data = stack_words[stack_fill];
                end
            end
            KIND_CHANGE: begin
                if (pos == 0 || pos > stack_fill) begin
                    r.status = ST_NOT_PRESENT;
                end else begin
                    stack_words[stack_fill - pos] = word;
                end
            end
            default: begin
                if (stack_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = stack_fill - 1; i >= 0; i--) begin
                        r.data = stack_words[i];
                        r.last = (i == 0);
                        step_results.push_back(r);
                    end
                    return;
                end
            end
        endcase
        step_results.push_back(r);
    endfunction

    function automatic t_stim_row stim_row(input logic [1:0] kind, input logic [31:0] value,
                                           input int pos, input int reps, input bit typed,
                                           input logic [STAT_W-1:0] status,
                                           input logic [31:0] data);
        t_stim_row row;
        row.kind   = kind;
        row.value  = value;
        row.pos    = pos[POS_W-1:0];
        row.reps   = reps;
        row.typed  = typed;
        row.status = status;
        row.data   = data;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("MISMATCH %s: got %h, want %h (result %0d)", what, got, want, results_out);
    endtask

    // drive one item from a falling edge and hold it until its transfer
    task automatic drive_item(input logic [1:0] kind, input logic signed [WORD_W-1:0] value,
                              input logic [POS_W-1:0] pos, input bit typed,
                              input logic [STAT_W-1:0] status,
                              input logic signed [WORD_W-1:0] data);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        s_tvalid     <= 1'b1;
        s_kind       <= kind;
        s_value      <= value;
        s_pos        <= pos;
        row_typed    <= typed;
        typed_status <= status;
        typed_data   <= data;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        @(negedge clk);
    endtask

    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin : monitor
        t_result want;
        t_result got;
        bit      moved;
        if (rst_n) begin
            moved = 1'b0;
            if (s_tvalid && s_tready) begin
                moved = 1'b1;
                items_in++;
                predict_stack_op(s_kind, s_value, s_pos);
                if (row_typed) begin
                    want.status = typed_status;
                    want.data   = typed_data;
                    want.last   = 1'b1;
                    awaited_results.push_back(want);
                end else begin
                    foreach (step_results[i]) awaited_results.push_back(step_results[i]);
                end
            end
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                got.status = m_tdata[2:0];
                got.data   = m_tdata[34:3];
                got.last   = m_tlast;
                if (got.status <= ST_EMPTY) status_seen[got.status]++;
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected result", got.data, '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.data !== want.data)
                        report_mismatch("data", got.data, want.data);
                    if (got.last !== want.last)
                        report_mismatch("last", 32'(got.last), 32'(want.last));
                end
                results_out++;
            end
            if (moved) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("Watchdog: no transfer for %0d cycles, %0d results awaited",
                             stall_cycles, awaited_results.size());
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [1:0]               kind;
        logic signed [WORD_W-1:0] value;
        int                       pos;
        int                       r;
        bit                       draining;
        int                       directed_count;

        directed_rows.push_back(stim_row(KIND_POP,     32'h0,        3, 1, 1, ST_UNDERFLOW, '1));
        directed_rows.push_back(stim_row(KIND_DISPLAY, 32'h0,        0, 1, 1, ST_EMPTY, '0));
        directed_rows.push_back(stim_row(KIND_CHANGE,  32'h1,        1, 1, 1, ST_NOT_PRESENT, '0));
        directed_rows.push_back(stim_row(KIND_PUSH,    32'h7FFFFFFF, 0, 1, 1, ST_OK, '0));
        directed_rows.push_back(stim_row(KIND_PUSH,    32'h80000000, 31, 1, 1, ST_OK, '0));
        directed_rows.push_back(stim_row(KIND_PUSH,    32'hFFFFFFFF, 0, 1, 0, ST_OK, '0));
        directed_rows.push_back(stim_row(KIND_PUSH,    32'h0,        0, 1, 0, ST_OK, '0));
        directed_rows.push_back(stim_row(KIND_CHANGE,  32'h5,        0, 1, 1, ST_NOT_PRESENT, '0));
        directed_rows.push_back(stim_row(KIND_CHANGE,  32'h6,        31, 1, 1, ST_NOT_PRESENT, '0));
        directed_rows.push_back(stim_row(KIND_CHANGE,  32'h55555555, 4, 1, 1, ST_OK, '0));
        directed_rows.push_back(stim_row(KIND_CHANGE,  32'hAAAAAAAA, 1, 1, 1, ST_OK, '0));
        directed_rows.push_back(stim_row(KIND_CHANGE,  32'h7,        5, 1, 1, ST_NOT_PRESENT, '0));
        directed_rows.push_back(stim_row(KIND_DISPLAY, 32'h0,        0, 1, 0, ST_OK, '0));
        directed_rows.push_back(stim_row(KIND_POP,     32'h0,        0, 1, 0, ST_OK, '0));
        directed_rows.push_back(stim_row(KIND_PUSH,    32'h12340000, 0, 13, 0, ST_OK, '0));
        directed_rows.push_back(stim_row(KIND_PUSH,    32'hDEADBEEF, 0, 1, 1, ST_OVERFLOW, '0));
        directed_rows.push_back(stim_row(KIND_CHANGE,  32'h0F0F0F0F, 16, 1, 0, ST_OK, '0));
        directed_rows.push_back(stim_row(KIND_CHANGE,  32'hF0F0F0F0, 17, 1, 1, ST_NOT_PRESENT, '0));
        directed_rows.push_back(stim_row(KIND_DISPLAY, 32'h0,        0, 1, 0, ST_OK, '0));
        directed_rows.push_back(stim_row(KIND_POP,     32'h0,        0, 16, 0, ST_OK, '0));
        directed_rows.push_back(stim_row(KIND_POP,     32'h0,        0, 1, 1, ST_UNDERFLOW, '1));
        directed_rows.push_back(stim_row(KIND_DISPLAY, 32'h0,        0, 1, 1, ST_EMPTY, '0));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i]) begin
            for (int k = 0; k < directed_rows[i].reps; k++) begin
                drive_item(directed_rows[i].kind, directed_rows[i].value + k,
                           directed_rows[i].pos, directed_rows[i].typed,
                           directed_rows[i].status, directed_rows[i].data);
            end
        end
        directed_count = items_in;

        draining = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= QUIET_FROM);
            if (stack_fill == DEPTH) draining = 1'b1;
            else if (stack_fill == 0) draining = 1'b0;
            else if ($urandom_range(0, 29) == 0) draining = !draining;
            r = $urandom_range(0, 99);
            if (draining)
                kind = (r < 25) ? KIND_PUSH : (r < 65) ? KIND_POP :
                       (r < 88) ? KIND_CHANGE : KIND_DISPLAY;
            else
                kind = (r < 55) ? KIND_PUSH : (r < 70) ? KIND_POP :
                       (r < 90) ? KIND_CHANGE : KIND_DISPLAY;
            case ($urandom_range(0, 7))
                0:       value = 32'h7FFFFFFF;
                1:       value = 32'h80000000;
                2:       value = $urandom_range(0, 1) ? -1 : 0;
                default: value = $urandom;
            endcase
            if (kind == KIND_CHANGE && stack_fill > 0 && $urandom_range(0, 4) != 0)
                pos = $urandom_range(1, stack_fill);
            else
                pos = $urandom_range(0, 31);
            drive_item(kind, value, pos[POS_W-1:0], 1'b0, ST_OK, '0);
        end
        s_tvalid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge clk);
        repeat (24) @(posedge clk);

        $display("Covered %0d items (%0d directed, %0d random) and %0d results checked.",
                 items_in, directed_count, items_in - directed_count, results_out);
        $display("Status counts: ok %0d, overflow %0d, underflow %0d, bad position %0d, empty %0d",
                 status_seen[ST_OK], status_seen[ST_OVERFLOW], status_seen[ST_UNDERFLOW],
                 status_seen[ST_NOT_PRESENT], status_seen[ST_EMPTY]);
        if (errors == 0 && awaited_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
src/bsu_pkg.sv
src/bsu_cell.sv
src/bounded_stack_with_indexed_update_unit.sv
tb/tb_top.sv
